// ===== rtl/u8q_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8q_pkg
// shared types and constants of the utf-8 check and quote escape unit
// ----------------------------------------------------------------------------
package u8q_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_DEL       = 8'h7F;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // end of string status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_UTF8 = 2'd1;
    localparam logic [1:0] ST_CTRL     = 2'd2;

    // one classified byte between the front and the back
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] status;
        logic       esc;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage
`default_nettype wire

// ===== rtl/u8q_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8q_in_if
// input byte channel: valid/ready with raw byte and end of string mark
// ----------------------------------------------------------------------------
interface u8q_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink (input valid, input in_byte, input is_final, output ready);
endinterface
`default_nettype wire

// ===== rtl/u8q_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8q_out_if
// output byte channel: valid/ready with escaped byte and framing/status
// ----------------------------------------------------------------------------
interface u8q_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic [1:0] status;

    modport source (
        output valid, output out_byte, output run_last, output string_end,
        output status, input ready
    );
    modport sink (
        input valid, input out_byte, input run_last, input string_end,
        input status, output ready
    );
endinterface
`default_nettype wire

// ===== rtl/utf8_check_and_quote_escape_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_check_and_quote_escape_unit
// streaming strict utf-8 checker with quote and backslash escaping
// ----------------------------------------------------------------------------
// Bytes of a string enter on i_in_chan, one transaction per byte, with
// is_final set on the last byte. Each byte leaves on o_out_chan as soon as it
// can; a double quote or a backslash is preceded by one extra backslash
// transaction (run_last low on it). Output goes out before validity is known:
// the transaction with string_end high carries the status (0 ok, 1 invalid
// utf-8, 2 control byte, invalid utf-8 taking precedence) and the consumer
// drops the whole string's output when it is not 0. The input takes one byte
// per cycle while the queue has room; the output port moves one byte per
// cycle while ready is high, so each escaped byte costs an extra output
// transaction, and a queue of QUEUE_DEPTH entries between the classifier and
// the output register absorbs that and any output stall. An accepted byte
// passes through the queue and then the output register before it is presented.
// After the final byte all checker state is back to its reset value.
// ----------------------------------------------------------------------------
module utf8_check_and_quote_escape_unit #(
    parameter int unsigned QUEUE_DEPTH = u8q_pkg::QUEUE_DEPTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    u8q_in_if.sink       i_in_chan,
    u8q_out_if.source    o_out_chan
);

    // front to queue
    u8q_pkg::t_push w_push;
    logic           w_push_ready;
    // queue to back
    u8q_pkg::t_head w_head;
    logic           w_pop;

    // utf-8 sequence tracking and per-byte classification
    u8q_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in_chan),
        .i_push_ready (w_push_ready),
        .o_push       (w_push)
    );

    // decouples input acceptance from escape expansion and output stalls
    u8q_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // registered output, inserts the escape backslash
    u8q_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out_chan)
    );

endmodule
`default_nettype wire

// ===== rtl/u8q_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8q_front
// accepts bytes, tracks utf-8 sequence state and classifies each byte
// ----------------------------------------------------------------------------
module u8q_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    u8q_in_if.sink            i_in,
    input  wire               i_push_ready,
    output u8q_pkg::t_push    o_push
);

    logic [1:0]  r_pend, n_pend;
    logic [1:0]  r_len, n_len;
    logic [20:0] r_acc, n_acc;
    logic        r_err, n_err;
    logic        r_ctrl, n_ctrl;
    logic [1:0]  w_status;
    logic [7:0]  w_b;
    logic        w_accept;

    function automatic logic cp_bad(input logic [20:0] cp, input logic [1:0] len);
        logic bad;
        bad = 1'b0;
        if (len == 2'd1 && cp < 21'h80) bad = 1'b1;
        if (len == 2'd2 && cp < 21'h800) bad = 1'b1;
        if (len == 2'd3 && cp < 21'h10000) bad = 1'b1;
        if (cp >= 21'hD800 && cp <= 21'hDFFF) bad = 1'b1;
        if (cp > 21'h10FFFF) bad = 1'b1;
        return bad;
    endfunction

    assign w_b      = i_in.in_byte;
    assign i_in.ready = i_push_ready;
    assign w_accept = i_in.valid && i_push_ready;

    always_comb begin
        n_pend   = r_pend;
        n_len    = r_len;
        n_acc    = r_acc;
        n_err    = r_err;
        n_ctrl   = r_ctrl;
        w_status = u8q_pkg::ST_OK;

        if (w_b < u8q_pkg::CHAR_SPACE || w_b == u8q_pkg::CHAR_DEL) begin
            n_ctrl = 1'b1;
        end

        if (r_pend != 2'd0) begin
            if (w_b[7:6] != 2'b10) begin
                // bad continuation, sequence dropped
                n_err  = 1'b1;
                n_pend = 2'd0;
                n_len  = 2'd0;
                n_acc  = '0;
            end else begin
                n_acc  = {r_acc[14:0], w_b[5:0]};
                n_pend = r_pend - 2'd1;
                if (n_pend == 2'd0) begin
                    if (cp_bad(n_acc, r_len)) begin
                        n_err = 1'b1;
                    end
                    n_len = 2'd0;
                    n_acc = '0;
                end
            end
        end else if (w_b[7] == 1'b0) begin
            n_pend = 2'd0;
        end else if (w_b[7:5] == 3'b110) begin
            n_len  = 2'd1;
            n_pend = 2'd1;
            n_acc  = {16'd0, w_b[4:0]};
        end else if (w_b[7:4] == 4'b1110) begin
            n_len  = 2'd2;
            n_pend = 2'd2;
            n_acc  = {17'd0, w_b[3:0]};
        end else if (w_b[7:3] == 5'b11110) begin
            n_len  = 2'd3;
            n_pend = 2'd3;
            n_acc  = {18'd0, w_b[2:0]};
        end else begin
            n_err = 1'b1;
        end

        if (i_in.is_final) begin
            // truncated sequence counts as bad utf-8
            if (n_pend != 2'd0) begin
                n_err = 1'b1;
            end
            if (n_err) begin
                w_status = u8q_pkg::ST_BAD_UTF8;
            end else if (n_ctrl) begin
                w_status = u8q_pkg::ST_CTRL;
            end
            n_pend = 2'd0;
            n_len  = 2'd0;
            n_acc  = '0;
            n_err  = 1'b0;
            n_ctrl = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_len  <= 2'd0;
            r_acc  <= '0;
            r_err  <= 1'b0;
            r_ctrl <= 1'b0;
        end else if (w_accept) begin
            r_pend <= n_pend;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_err  <= n_err;
            r_ctrl <= n_ctrl;
        end
    end

    always_comb begin
        o_push.valid        = i_in.valid;
        o_push.entry.data   = w_b;
        o_push.entry.fin    = i_in.is_final;
        o_push.entry.status = w_status;
        o_push.entry.esc    = (w_b == u8q_pkg::CHAR_DQUOTE) ||
                              (w_b == u8q_pkg::CHAR_BACKSLASH);
    end

endmodule
`default_nettype wire

// ===== rtl/u8q_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8q_queue
// short first-in first-out queue of classified bytes
// ----------------------------------------------------------------------------
module u8q_queue #(
    parameter int unsigned DEPTH = u8q_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  u8q_pkg::t_push    i_push,
    output logic              o_push_ready,
    output u8q_pkg::t_head    o_head,
    input  wire               i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u8q_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && (r_count != '0);

    always_comb begin
        o_head.valid = (r_count != '0);
        o_head.entry = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/u8q_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8q_back
// output register: emits an escape backslash when needed, then the byte
// ----------------------------------------------------------------------------
module u8q_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  u8q_pkg::t_head    i_head,
    output logic              o_pop,
    u8q_out_if.source         o_out
);

    u8q_pkg::t_entry r_cur;
    logic            r_valid;
    logic            r_esc_pend;
    logic            w_fire;
    logic            w_free;

    assign w_fire = r_valid && o_out.ready;
    // nothing is held, or the held byte leaves and no escape is outstanding
    assign w_free = !r_valid || (w_fire && !r_esc_pend);
    assign o_pop  = w_free && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_esc_pend <= 1'b0;
        end else if (w_free) begin
            r_valid    <= i_head.valid;
            r_esc_pend <= i_head.valid && i_head.entry.esc;
        end else if (w_fire) begin
            r_esc_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head.entry;
        end
    end

    always_comb begin
        o_out.valid      = r_valid;
        o_out.out_byte   = r_esc_pend ? u8q_pkg::CHAR_BACKSLASH : r_cur.data;
        o_out.run_last   = !r_esc_pend;
        o_out.string_end = !r_esc_pend && r_cur.fin;
        o_out.status     = r_esc_pend ? u8q_pkg::ST_OK : r_cur.status;
    end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming utf-8 check and quote escape unit
// ----------------------------------------------------------------------------
// A short table of hand-picked byte strings runs first: range extremes, both
// escaped characters and every kind of utf-8 fault. Random strings follow.
// Most of them are well-formed characters with random code points; the rest
// are overlong or out-of-range forms, surrogates, cut-off sequences and raw
// noise bytes. Each input transaction feeds an in-bench copy of the checker,
// which queues the escaped bytes and the end of string status. Every output
// transaction is checked field by field against the oldest queued entry.
// Both channels stall at random, apart from one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RANDOM_BYTES  = 750;
    localparam int unsigned IDLE_PERCENT  = 16;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned DIRECTED_ROWS = 26;

    // one escaped output byte as it should leave the unit
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
        logic [1:0] status;
    } t_out_item;

    // one input byte of the directed table; a status is typed in where obvious
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       status_given;
        logic [1:0] status;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    u8q_in_if  in_chan ();
    u8q_out_if out_chan ();

    utf8_check_and_quote_escape_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan)
    );

    // checker copy: state of the sequence being decoded and sticky flags
    logic [1:0]  cont_left;
    logic [1:0]  seq_len;
    logic [20:0] cp_acc;
    logic        utf_err;
    logic        ctrl_seen;

    t_out_item   expected_bytes_q[$];
    logic [7:0]  byte_plan[$];
    t_stim_row   directed_rows[DIRECTED_ROWS];

    // table hint travels with the byte so the monitor sees it at acceptance
    logic        hint_given;
    logic [1:0]  hint_status;
    logic        calm;

    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // run one accepted byte through the checker copy and queue its outputs
    function automatic void check_and_escape_byte(input logic [7:0] data, input logic fin,
                                                  input logic given, input logic [1:0] given_st);
        logic [20:0] acc;
        logic        bad;
        logic [1:0]  st;
        t_out_item   item;

        if (data < u8q_pkg::CHAR_SPACE || data == u8q_pkg::CHAR_DEL) ctrl_seen = 1'b1;

        if (cont_left != 2'd0) begin
            if (data[7:6] != 2'b10) begin
                // bad continuation: drop the sequence, byte is not a new lead
                utf_err   = 1'b1;
                cont_left = 2'd0;
                seq_len   = 2'd0;
                cp_acc    = '0;
            end else begin
                acc       = {cp_acc[14:0], data[5:0]};
                cp_acc    = acc;
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    bad = (seq_len == 2'd1 && acc < 21'h80)
                       || (seq_len == 2'd2 && acc < 21'h800)
                       || (seq_len == 2'd3 && acc < 21'h10000)
                       || (acc >= 21'hD800 && acc <= 21'hDFFF)
                       || (acc > 21'h10FFFF);
                    if (bad) utf_err = 1'b1;
                    seq_len = 2'd0;
                    cp_acc  = '0;
                end
            end
        end else if (data[7] == 1'b0) begin
            // plain ascii, nothing to track
        end else if (data[7:5] == 3'b110) begin
            seq_len = 2'd1; cp_acc = 21'(data[4:0]); cont_left = 2'd1;
        end else if (data[7:4] == 4'b1110) begin
            seq_len = 2'd2; cp_acc = 21'(data[3:0]); cont_left = 2'd2;
        end else if (data[7:3] == 5'b11110) begin
            seq_len = 2'd3; cp_acc = 21'(data[2:0]); cont_left = 2'd3;
        end else begin
            utf_err = 1'b1;
        end

        st = u8q_pkg::ST_OK;
        if (fin) begin
            // cut-off sequence counts as invalid; invalid outranks control
            if (cont_left != 2'd0) utf_err = 1'b1;
            if (utf_err) st = u8q_pkg::ST_BAD_UTF8;
            else if (ctrl_seen) st = u8q_pkg::ST_CTRL;
            cont_left = '0; seq_len = '0; cp_acc = '0;
            utf_err = 1'b0; ctrl_seen = 1'b0;
            if (given) st = given_st;
        end

        if (data == u8q_pkg::CHAR_DQUOTE || data == u8q_pkg::CHAR_BACKSLASH) begin
            item = '{u8q_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, u8q_pkg::ST_OK};
            expected_bytes_q = {expected_bytes_q, item};
        end
        item = '{data, 1'b1, fin, fin ? st : u8q_pkg::ST_OK};
        expected_bytes_q = {expected_bytes_q, item};
    endfunction

    // utf-8 encode a code point; keep < nbytes gives a cut-off sequence
    function automatic void push_encoded(input logic [20:0] cp, input int unsigned nbytes,
                                         input int unsigned keep);
        logic [7:0] seq[4];
        case (nbytes)
            1: seq[0] = {1'b0, cp[6:0]};
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < int'(keep); i++) byte_plan = {byte_plan, seq[i]};
    endfunction

    // append one random character, mostly well formed
    function automatic void add_char();
        int unsigned pick;
        int unsigned len;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            cp = 21'($urandom_range(8'h20, 8'h7E));
            if ($urandom_range(0, 3) == 0)
                cp = $urandom_range(0, 1) ? 21'(u8q_pkg::CHAR_DQUOTE)
                                          : 21'(u8q_pkg::CHAR_BACKSLASH);
            push_encoded(cp, 1, 1);
        end else if (pick < 36) begin
            cp = $urandom_range(0, 1) ? 21'(u8q_pkg::CHAR_DEL) : 21'($urandom_range(0, 31));
            push_encoded(cp, 1, 1);
        end else if (pick < 50) begin
            push_encoded(21'($urandom_range(21'h80, 21'h7FF)), 2, 2);
        end else if (pick < 62) begin
            push_encoded(21'($urandom_range(21'h800, 21'hFFFF)), 3, 3);
        end else if (pick < 72) begin
            push_encoded(21'($urandom_range(21'h10000, 21'h10FFFF)), 4, 4);
        end else if (pick < 78) begin
            // any value the length can carry: overlong and beyond the top
            len = $urandom_range(2, 4);
            push_encoded(21'($urandom_range(0, (1 << (5 * len + 1)) - 1)), len, len);
        end else if (pick < 84) begin
            len = $urandom_range(2, 4);
            push_encoded(21'($urandom_range(0, (1 << (5 * len + 1)) - 1)), len,
                         $urandom_range(1, len - 1));
        end else if (pick < 89) begin
            push_encoded(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3);
        end else begin
            byte_plan = {byte_plan, 8'($urandom_range(0, 255))};
        end
    endfunction

    // present one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] data, input logic fin,
                             input logic given, input logic [1:0] st);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_chan.valid    <= 1'b1;
        in_chan.in_byte  <= data;
        in_chan.is_final <= fin;
        hint_given       <= given;
        hint_status      <= st;
        @(posedge i_clk);
        while (!in_chan.ready) @(posedge i_clk);
    endtask

    // output side back-pressure
    initial begin
        out_chan.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // monitor: feed the checker copy on input transactions, check outputs
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        logic      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_chan.valid && in_chan.ready) begin
                moved = 1'b1;
                check_and_escape_byte(in_chan.in_byte, in_chan.is_final,
                                      hint_given, hint_status);
            end
            if (out_chan.valid && out_chan.ready) begin
                moved = 1'b1;
                got = '{out_chan.out_byte, out_chan.run_last,
                        out_chan.string_end, out_chan.status};
                if (expected_bytes_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected output byte %02h", got.data));
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (got.data !== want.data)
                        log_mismatch($sformatf("out_byte %02h, want %02h",
                                               got.data, want.data));
                    if (got.run_last !== want.run_last)
                        log_mismatch($sformatf("run_last %b, want %b on byte %02h",
                                               got.run_last, want.run_last, want.data));
                    if (got.string_end !== want.string_end)
                        log_mismatch($sformatf("string_end %b, want %b on byte %02h",
                                               got.string_end, want.string_end, want.data));
                    if (got.status !== want.status)
                        log_mismatch($sformatf("status %0d, want %0d on byte %02h",
                                               got.status, want.status, want.data));
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int unsigned random_sent;
        int unsigned nchars;

        cont_left = '0; seq_len = '0; cp_acc = '0;
        utf_err = 1'b0; ctrl_seen = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        calm           = 1'b0;
        hint_given     = 1'b0;
        hint_status    = u8q_pkg::ST_OK;
        in_chan.valid    = 1'b0;
        in_chan.in_byte  = 8'h00;
        in_chan.is_final = 1'b0;
        i_rst_n          = 1'b0;

        directed_rows = '{
            // single bytes straight after reset and at the range ends
            '{8'h41, 1'b1, 1'b1, u8q_pkg::ST_OK},
            '{8'h00, 1'b1, 1'b1, u8q_pkg::ST_CTRL},
            '{8'hFF, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8},
            '{8'h7F, 1'b1, 1'b1, u8q_pkg::ST_CTRL},
            // both escaped characters
            '{8'h22, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h5C, 1'b1, 1'b1, u8q_pkg::ST_OK},
            // overlong two-byte form
            '{8'hC0, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h80, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8},
            // surrogate
            '{8'hED, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'hA0, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h80, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8},
            // one past the highest code point
            '{8'hF4, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h90, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h80, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h80, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8},
            // highest legal code point, left to the checker copy
            '{8'hF4, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h8F, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'hBF, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'hBF, 1'b1, 1'b0, u8q_pkg::ST_OK},
            // bad continuation, the quote is escaped but not a new lead
            '{8'hE2, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h22, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8},
            // sequence cut off by the end of string
            '{8'hE2, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h82, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8},
            // stray continuation, then a control byte: invalid wins
            '{8'h80, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h01, 1'b0, 1'b0, u8q_pkg::ST_OK},
            '{8'h5C, 1'b1, 1'b1, u8q_pkg::ST_BAD_UTF8}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_byte(directed_rows[r].data, directed_rows[r].fin,
                      directed_rows[r].status_given, directed_rows[r].status);

        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            byte_plan.delete();
            nchars = $urandom_range(1, 6);
            repeat (nchars) add_char();
            foreach (byte_plan[i]) begin
                // one stretch at full rate on both sides
                calm <= (random_sent >= 300 && random_sent < 420);
                send_byte(byte_plan[i], i == byte_plan.size() - 1, 1'b0, u8q_pkg::ST_OK);
                random_sent++;
            end
        end
        in_chan.valid <= 1'b0;

        while (expected_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
